// ===== sv/aeps_pkg.sv =====
// ----------------------------------------------------------------------------
// aeps_pkg
// shared constants, types and helpers of the active/expired priority scheduler
// ----------------------------------------------------------------------------
package aeps_pkg;

	localparam int LEVELS      = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int NQUEUES     = 2 * LEVELS;
	localparam int STORE_DEPTH = NQUEUES * QUEUE_DEPTH;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int QW = $clog2(NQUEUES);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IDW = 8;

	typedef enum logic [1:0] {
		STAT_ADDED   = 2'd0,
		STAT_GRANTED = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_DROPPED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REQ_ADD = 1'b0,
		REQ_GET = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SEARCH,
		S_READ
	} state_t;

	// one pointer/count update on one queue
	typedef struct packed {
		logic          push;
		logic          pop;
		logic [QW-1:0] q;
	} qop_t;

	typedef struct packed {
		logic [PW-1:0]      ptr;
		logic               full;
		logic [NQUEUES-1:0] nonempty;
	} qstat_t;

	function automatic logic [LW-1:0] clamp_level(input logic [2:0] v);
		logic [LW-1:0] r;
		if (int'(v) >= LEVELS) begin
			r = LW'(LEVELS - 1);
		end else begin
			r = LW'(v);
		end
		return r;
	endfunction

	function automatic logic [QW-1:0] qnum(input logic bank, input logic [LW-1:0] lv);
		logic [QW-1:0] r;
		if (bank) begin
			r = QW'(LEVELS) + QW'(lv);
		end else begin
			r = QW'(lv);
		end
		return r;
	endfunction

endpackage

// ===== sv/aeps_req_if.sv =====
// ----------------------------------------------------------------------------
// aeps_req_if
// request channel: add or get, with process id and priorities
// ----------------------------------------------------------------------------
interface aeps_req_if;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [7:0]       proc_id;
	logic signed [2:0] dyn_prio;
	logic [1:0]       reset_prio;

	modport source (output valid, req_type, proc_id, dyn_prio, reset_prio, input ready);
	modport sink   (input valid, req_type, proc_id, dyn_prio, reset_prio, output ready);
endinterface

// ===== sv/aeps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aeps_rsp_if
// response channel: status, granted id and level
// ----------------------------------------------------------------------------
interface aeps_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] grant_id;
	logic [1:0] grant_level;

	modport source (output valid, status, grant_id, grant_level, input ready);
	modport sink   (input valid, status, grant_id, grant_level, output ready);
endinterface

// ===== sv/aeps_ram.sv =====
// ----------------------------------------------------------------------------
// aeps_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module aeps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/aeps_queue_ctl.sv =====
// ----------------------------------------------------------------------------
// aeps_queue_ctl
// head/tail pointers and fill counts of all queues, one shared update unit
// ----------------------------------------------------------------------------
module aeps_queue_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  aeps_pkg::qop_t    op,
	output aeps_pkg::qstat_t  stat
);

	logic [aeps_pkg::PW-1:0] head_q  [aeps_pkg::NQUEUES];
	logic [aeps_pkg::PW-1:0] tail_q  [aeps_pkg::NQUEUES];
	logic [aeps_pkg::CW-1:0] count_q [aeps_pkg::NQUEUES];

	logic [aeps_pkg::PW-1:0] sel_ptr;
	logic [aeps_pkg::PW-1:0] nxt_ptr;
	logic [aeps_pkg::CW-1:0] nxt_count;

	// shared increment unit for whichever pointer moves
	always_comb begin
		sel_ptr = op.pop ? head_q[op.q] : tail_q[op.q];
		if (sel_ptr == aeps_pkg::PW'(aeps_pkg::QUEUE_DEPTH - 1)) begin
			nxt_ptr = '0;
		end else begin
			nxt_ptr = sel_ptr + aeps_pkg::PW'(1);
		end
		nxt_count = op.pop ? count_q[op.q] - aeps_pkg::CW'(1) : count_q[op.q] + aeps_pkg::CW'(1);
	end

	always_comb begin
		stat.ptr  = sel_ptr;
		stat.full = (count_q[op.q] == aeps_pkg::CW'(aeps_pkg::QUEUE_DEPTH));
		for (int i = 0; i < aeps_pkg::NQUEUES; i++) begin
			stat.nonempty[i] = (count_q[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aeps_pkg::NQUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (op.push || op.pop) begin
			count_q[op.q] <= nxt_count;
			if (op.pop) begin
				head_q[op.q] <= nxt_ptr;
			end else begin
				tail_q[op.q] <= nxt_ptr;
			end
		end
	end

endmodule

// ===== sv/active_expired_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler_core
// two banks of per-level fifo queues, ids held in one ram, small sequencer
// ----------------------------------------------------------------------------
// an add passes from idle through the add state, which loads its result; a get passes
// through search and read, or searches again after a bank swap when the active bank is
// empty; a new request is taken only in idle, once the last one is through, as the
// single pointer update unit and the registered read of the id ram serve one at a time
// reset: all queues empty, bank zero active, no response pending
module active_expired_priority_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	aeps_req_if.sink    req,
	aeps_rsp_if.source  rsp
);

	aeps_pkg::state_t state_q, state_d;

	logic [aeps_pkg::IDW-1:0] proc_id_q;
	logic [2:0]               dyn_prio_q;
	logic [1:0]               reset_prio_q;

	logic                     bank_q;
	logic                     swapped_q;
	logic [aeps_pkg::LW-1:0]  level_q;

	logic                     rsp_valid_q;
	aeps_pkg::status_t        rsp_status_q;
	logic [aeps_pkg::IDW-1:0] rsp_id_q;
	logic [1:0]               rsp_level_q;

	aeps_pkg::qop_t   qop;
	aeps_pkg::qstat_t qstat;

	logic                        accept;
	logic [aeps_pkg::LW-1:0]     add_level;
	logic                        add_bank;
	logic [aeps_pkg::LEVELS-1:0] active_ne;
	logic                        found;
	logic [aeps_pkg::LW-1:0]     found_lv;
	logic [aeps_pkg::AW-1:0]     ram_addr;
	logic [aeps_pkg::IDW-1:0]    ram_rdata;

	logic                     flip_bank;
	logic                     load_rsp;
	aeps_pkg::status_t        rsp_status_d;
	logic [aeps_pkg::IDW-1:0] rsp_id_d;

	assign req.ready = (state_q == aeps_pkg::S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// expired adds go to the other bank at the reset level
	always_comb begin
		if (dyn_prio_q[2]) begin
			add_bank  = ~bank_q;
			add_level = aeps_pkg::clamp_level({1'b0, reset_prio_q});
		end else begin
			add_bank  = bank_q;
			add_level = aeps_pkg::clamp_level(dyn_prio_q);
		end
	end

	// highest non-empty level of the active bank
	always_comb begin
		found    = 1'b0;
		found_lv = '0;
		for (int lv = 0; lv < aeps_pkg::LEVELS; lv++) begin
			active_ne[lv] = qstat.nonempty[aeps_pkg::qnum(bank_q, aeps_pkg::LW'(lv))];
			if (active_ne[lv]) begin
				found    = 1'b1;
				found_lv = aeps_pkg::LW'(lv);
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		qop.push     = 1'b0;
		qop.pop      = 1'b0;
		qop.q        = aeps_pkg::qnum(add_bank, add_level);
		flip_bank    = 1'b0;
		load_rsp     = 1'b0;
		rsp_status_d = aeps_pkg::STAT_ADDED;
		rsp_id_d     = '0;
		unique case (state_q)
			aeps_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (req.req_type == aeps_pkg::REQ_GET) ? aeps_pkg::S_SEARCH
					                                             : aeps_pkg::S_ADD;
				end
			end
			aeps_pkg::S_ADD: begin
				load_rsp = 1'b1;
				if (qstat.full) begin
					rsp_status_d = aeps_pkg::STAT_DROPPED;
				end else begin
					qop.push = 1'b1;
				end
				state_d = aeps_pkg::S_IDLE;
			end
			aeps_pkg::S_SEARCH: begin
				qop.q = aeps_pkg::qnum(bank_q, found_lv);
				if (found) begin
					qop.pop = 1'b1;
					state_d = aeps_pkg::S_READ;
				end else if (!swapped_q) begin
					flip_bank = 1'b1;
				end else begin
					load_rsp     = 1'b1;
					rsp_status_d = aeps_pkg::STAT_EMPTY;
					state_d      = aeps_pkg::S_IDLE;
				end
			end
			aeps_pkg::S_READ: begin
				load_rsp     = 1'b1;
				rsp_status_d = aeps_pkg::STAT_GRANTED;
				rsp_id_d     = ram_rdata;
				state_d      = aeps_pkg::S_IDLE;
			end
			default: begin
				state_d = aeps_pkg::S_IDLE;
			end
		endcase
	end

	assign ram_addr = aeps_pkg::AW'(qop.q) * aeps_pkg::AW'(aeps_pkg::QUEUE_DEPTH)
	                  + aeps_pkg::AW'(qstat.ptr);

	aeps_queue_ctl u_queue_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (qop),
		.stat   (qstat)
	);

	aeps_ram #(
		.WIDTH (aeps_pkg::IDW),
		.DEPTH (aeps_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (qop.push),
		.waddr (ram_addr),
		.wdata (proc_id_q),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aeps_pkg::S_IDLE;
			bank_q      <= 1'b0;
			swapped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (flip_bank) begin
				bank_q    <= ~bank_q;
				swapped_q <= 1'b1;
			end else if (accept) begin
				swapped_q <= 1'b0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			proc_id_q    <= req.proc_id;
			dyn_prio_q   <= req.dyn_prio;
			reset_prio_q <= req.reset_prio;
		end
		if (qop.pop) begin
			level_q <= found_lv;
		end
		if (load_rsp) begin
			rsp_status_q <= rsp_status_d;
			rsp_id_q     <= rsp_id_d;
			rsp_level_q  <= (rsp_status_d == aeps_pkg::STAT_GRANTED) ? 2'(level_q) : 2'd0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.grant_id    = rsp_id_q;
	assign rsp.grant_level = rsp_level_q;

endmodule

// ===== verif/tb_active_expired_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_active_expired_priority_scheduler_core
// adds and gets run through the scheduler with random gaps on both channels;
// a local copy of both banks of queues predicts every response, which is
// checked field by field in order of arrival
// ----------------------------------------------------------------------------
module tb_active_expired_priority_scheduler_core;

	typedef struct packed {
		aeps_pkg::status_t status;
		logic [7:0]        id;
		logic [1:0]        level;
	} sched_result_t;

	logic clk;
	logic arst_n;

	aeps_req_if req_ch();
	aeps_rsp_if rsp_ch();

	active_expired_priority_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the scheduler state
	logic [7:0]  mirror_ids [aeps_pkg::NQUEUES][aeps_pkg::QUEUE_DEPTH];
	int unsigned mirror_head [aeps_pkg::NQUEUES];
	int unsigned mirror_tail [aeps_pkg::NQUEUES];
	int unsigned mirror_fill [aeps_pkg::NQUEUES];
	bit          mirror_bank;

	sched_result_t expected_responses[$];
	int unsigned   mismatch_count;
	int unsigned   requests_sent;
	int unsigned   responses_seen;
	int unsigned   status_tally [4];
	int unsigned   swap_count;
	bit            steady_source;
	bit            steady_sink;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout: %0d responses still outstanding", expected_responses.size());
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// mostly short idles, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) begin
			return $urandom_range(1, 2);
		end else if (r < 90) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(10, 40);
	endfunction

	// take the head of the highest non-empty level of the active bank
	function automatic bit pop_highest(output int lvl, output logic [7:0] id);
		int q;
		for (int l = aeps_pkg::LEVELS - 1; l >= 0; l--) begin
			q = mirror_bank * aeps_pkg::LEVELS + l;
			if (mirror_fill[q] != 0) begin
				id = mirror_ids[q][mirror_head[q]];
				mirror_head[q] = (mirror_head[q] + 1) % aeps_pkg::QUEUE_DEPTH;
				mirror_fill[q]--;
				lvl = l;
				return 1'b1;
			end
		end
		lvl = -1;
		id = '0;
		return 1'b0;
	endfunction

	task automatic predict_response(input aeps_pkg::req_t kind, input logic [7:0] id,
			input logic signed [2:0] dp, input logic [1:0] rp, output sched_result_t r);
		int q;
		int lvl;
		int target;
		bit found;
		logic [7:0] got;
		r.status = aeps_pkg::STAT_ADDED;
		r.id = '0;
		r.level = '0;
		if (kind == aeps_pkg::REQ_ADD) begin
			// expired quantum goes to the other bank at its reset level
			if (dp < 0) begin
				target = (rp >= aeps_pkg::LEVELS) ? aeps_pkg::LEVELS - 1 : int'(rp);
				q = (mirror_bank ^ 1'b1) * aeps_pkg::LEVELS + target;
			end else begin
				target = (dp >= aeps_pkg::LEVELS) ? aeps_pkg::LEVELS - 1 : int'(dp);
				q = mirror_bank * aeps_pkg::LEVELS + target;
			end
			if (mirror_fill[q] >= aeps_pkg::QUEUE_DEPTH) begin
				r.status = aeps_pkg::STAT_DROPPED;
			end else begin
				mirror_ids[q][mirror_tail[q]] = id;
				mirror_tail[q] = (mirror_tail[q] + 1) % aeps_pkg::QUEUE_DEPTH;
				mirror_fill[q]++;
			end
		end else begin
			found = pop_highest(lvl, got);
			if (!found) begin
				mirror_bank = ~mirror_bank;
				swap_count++;
				found = pop_highest(lvl, got);
			end
			if (found) begin
				r.status = aeps_pkg::STAT_GRANTED;
				r.id = got;
				r.level = 2'(lvl);
			end else begin
				r.status = aeps_pkg::STAT_EMPTY;
			end
		end
		status_tally[r.status]++;
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_request(input aeps_pkg::req_t kind, input logic [7:0] id,
			input logic signed [2:0] dp, input logic [1:0] rp);
		int unsigned gap;
		sched_result_t want;
		gap = (steady_source || $urandom_range(99) >= 40) ? 0 : idle_len();
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.req_type = kind;
		req_ch.proc_id = id;
		req_ch.dyn_prio = dp;
		req_ch.reset_prio = rp;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_response(kind, id, dp, rp, want);
		expected_responses.push_back(want);
		requests_sent++;
		@(negedge clk);
	endtask

	// response side stalls
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!steady_sink && $urandom_range(99) < 30) hold_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			responses_seen++;
			if (expected_responses.size() == 0) begin
				report_mismatch($sformatf("response %0d with nothing outstanding", responses_seen));
			end else begin
				want = expected_responses.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("response %0d status: expected %0d got %0d",
						responses_seen, want.status, rsp_ch.status));
				if (rsp_ch.grant_id !== want.id)
					report_mismatch($sformatf("response %0d grant_id: expected %0d got %0d",
						responses_seen, want.id, rsp_ch.grant_id));
				if (rsp_ch.grant_level !== want.level)
					report_mismatch($sformatf("response %0d grant_level: expected %0d got %0d",
						responses_seen, want.level, rsp_ch.grant_level));
			end
		end
	end

	task automatic test_empty_scheduler();
		// nothing queued: banks swap and the get reports empty
		send_request(aeps_pkg::REQ_GET, 8'hFF, -3'sd1, 2'd3);
		send_request(aeps_pkg::REQ_GET, 8'h00, 3'sd0, 2'd0);
	endtask

	task automatic test_priority_order();
		send_request(aeps_pkg::REQ_ADD, 8'h00, 3'sd0, 2'd0);
		send_request(aeps_pkg::REQ_ADD, 8'hFF, 3'sd3, 2'd0);
		send_request(aeps_pkg::REQ_ADD, 8'h5A, 3'sd3, 2'd1);
		send_request(aeps_pkg::REQ_ADD, 8'hA5, 3'sd1, 2'd2);
		send_request(aeps_pkg::REQ_ADD, 8'h3C, 3'sd2, 2'd3);
		repeat (5) send_request(aeps_pkg::REQ_GET, 8'h00, 3'sd0, 2'd0);
	endtask

	task automatic test_expired_requeue();
		send_request(aeps_pkg::REQ_ADD, 8'h11, -3'sd1, 2'd2);
		send_request(aeps_pkg::REQ_ADD, 8'h22, -3'sd4, 2'd3);
		send_request(aeps_pkg::REQ_ADD, 8'h33, 3'sd2, 2'd1);
		// first get served from the active bank, the next two after a swap
		repeat (3) send_request(aeps_pkg::REQ_GET, 8'h00, 3'sd0, 2'd0);
		send_request(aeps_pkg::REQ_ADD, 8'h44, -3'sd2, 2'd0);
		send_request(aeps_pkg::REQ_GET, 8'hC3, -3'sd3, 2'd1);
		// both banks drained: swap again and report empty
		send_request(aeps_pkg::REQ_GET, 8'h00, 3'sd0, 2'd0);
	endtask

	task automatic test_queue_full();
		// one more than the queue holds, the last add is dropped
		for (int i = 0; i <= aeps_pkg::QUEUE_DEPTH; i++)
			send_request(aeps_pkg::REQ_ADD, 8'(8'h80 + i), 3'sd1, 2'(i));
	endtask

	task automatic test_random_traffic(input int unsigned total);
		int unsigned sent;
		int unsigned add_pct;
		int unsigned round_len;
		logic signed [2:0] hot_dp;
		logic signed [2:0] dp;
		logic [1:0] hot_rp;
		logic [1:0] rp;
		sent = 0;
		while (sent < total) begin
			// rounds lean toward filling or draining so drops, swaps and empties all occur
			case ($urandom_range(3))
				0: add_pct = 25;
				1: add_pct = 50;
				2: add_pct = 75;
				default: add_pct = 90;
			endcase
			round_len = $urandom_range(40, 120);
			hot_dp = 3'($urandom);
			hot_rp = 2'($urandom);
			steady_source = ($urandom_range(3) == 0);
			steady_sink = ($urandom_range(3) == 0);
			for (int unsigned i = 0; i < round_len && sent < total; i++) begin
				dp = ($urandom_range(1) == 0) ? hot_dp : 3'($urandom);
				rp = ($urandom_range(1) == 0) ? hot_rp : 2'($urandom);
				if ($urandom_range(99) < add_pct)
					send_request(aeps_pkg::REQ_ADD, 8'($urandom), dp, rp);
				else
					send_request(aeps_pkg::REQ_GET, 8'($urandom), dp, rp);
				sent++;
			end
		end
		steady_source = 1'b0;
		steady_sink = 1'b0;
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = aeps_pkg::REQ_ADD;
		req_ch.proc_id = '0;
		req_ch.dyn_prio = '0;
		req_ch.reset_prio = '0;
		steady_source = 1'b0;
		steady_sink = 1'b0;
		mismatch_count = 0;
		requests_sent = 0;
		responses_seen = 0;
		swap_count = 0;
		for (int s = 0; s < 4; s++) status_tally[s] = 0;
		for (int q = 0; q < aeps_pkg::NQUEUES; q++) begin
			mirror_head[q] = 0;
			mirror_tail[q] = 0;
			mirror_fill[q] = 0;
		end
		mirror_bank = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_empty_scheduler();
		test_priority_order();
		test_expired_requeue();
		test_queue_full();
		test_random_traffic(1910);

		req_ch.valid = 1'b0;
		while (expected_responses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_responses.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));

		$display("run covered %0d requests: %0d added, %0d dropped on a full queue",
			requests_sent, status_tally[aeps_pkg::STAT_ADDED],
			status_tally[aeps_pkg::STAT_DROPPED]);
		$display("gets: %0d granted, %0d found both banks empty, %0d bank swaps",
			status_tally[aeps_pkg::STAT_GRANTED], status_tally[aeps_pkg::STAT_EMPTY],
			swap_count);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/aeps_pkg.sv
sv/aeps_req_if.sv
sv/aeps_rsp_if.sv
sv/aeps_ram.sv
sv/aeps_queue_ctl.sv
sv/active_expired_priority_scheduler_core.sv
verif/tb_active_expired_priority_scheduler_core.sv
